// ===== rtl/tet_pkg.sv =====
// ----------------------------------------------------------------------------
// tet_pkg: shared types and constants of the task entry table
// Entry layout, per-cell control and status groups, mode and status codes.
// ----------------------------------------------------------------------------
package tet_pkg;

  localparam int DEFAULT_DEPTH   = 32;
  localparam int DEFAULT_BUCKETS = 23;
  // a bucket index stays below 256 buckets
  localparam int BUCKET_W        = 8;

  localparam logic [2:0] MODE_REG   = 3'd0;
  localparam logic [2:0] MODE_REM   = 3'd1;
  localparam logic [2:0] MODE_FIND  = 3'd2;
  localparam logic [2:0] MODE_FINDI = 3'd3;
  localparam logic [2:0] MODE_LOST  = 3'd4;
  localparam logic [2:0] MODE_LIST  = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_CONNLOST = 2'd3;

  localparam logic signed [16:0] SOCK_LOST = -17'sd1;

  typedef struct packed {
    logic [30:0]          task_id;
    logic signed [16:0]   socket;
    logic [15:0]          port;
    logic [1:0]           refs;
    logic                 eof;
    logic [BUCKET_W-1:0]  bucket;
  } tet_entry_t;

  typedef struct packed {
    logic load;
    logic shift;
    logic kill;
    logic dec;
    logic lose;
  } tet_cell_ctrl_t;

  typedef struct packed {
    logic valid;
    logic task_hit;
    logic sock_hit;
    logic bucket_hit;
  } tet_cell_flags_t;

endpackage

// ===== rtl/tet_mod.sv =====
// ----------------------------------------------------------------------------
// tet_mod: bucket index unit
// Reduces a task id modulo the bucket count in three pipelined steps: fold
// the id bytes by their weights, reciprocal multiply, subtract the multiple.
// ----------------------------------------------------------------------------
module tet_mod #(
  parameter int BUCKETS = tet_pkg::DEFAULT_BUCKETS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [30:0]                  din,
  output logic                         done,
  output logic [tet_pkg::BUCKET_W-1:0] rem
);

  // weight of each id byte, already reduced by the bucket count
  localparam logic [7:0]  C0    = 8'(1 % BUCKETS);
  localparam logic [7:0]  C1    = 8'(256 % BUCKETS);
  localparam logic [7:0]  C2    = 8'(65536 % BUCKETS);
  localparam logic [7:0]  C3    = 8'(16777216 % BUCKETS);
  // rounded-up reciprocal, exact for folded sums below 2^18
  localparam logic [26:0] RECIP = 27'((67108864 + BUCKETS - 1) / BUCKETS);
  localparam logic [17:0] BK    = 18'(BUCKETS);

  logic [15:0]                  p0, p1, p2, p3;
  logic [17:0]                  fold;
  logic [44:0]                  prod;
  logic [17:0]                  qb;
  logic [17:0]                  diff;
  logic                         st1_r, st2_r, done_r;
  logic [17:0]                  fold_r;
  logic [17:0]                  q_r;
  logic [tet_pkg::BUCKET_W-1:0] rem_r;

  // the folded sum stays below 4 * 255 * 255, so 18 bits hold it
  always_comb begin
    p0   = 16'(din[7:0])   * 16'(C0);
    p1   = 16'(din[15:8])  * 16'(C1);
    p2   = 16'(din[23:16]) * 16'(C2);
    p3   = 16'(din[30:24]) * 16'(C3);
    fold = 18'(p0) + 18'(p1) + 18'(p2) + 18'(p3);
    prod = 45'(fold_r) * 45'(RECIP);
    qb   = q_r * BK;
    diff = fold_r - qb;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st1_r  <= 1'b0;
      st2_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      st1_r  <= start;
      st2_r  <= st1_r;
      done_r <= st2_r;
    end
    if (start) begin
      fold_r <= fold;
    end
    if (st1_r) begin
      q_r <= prod[43:26];
    end
    if (st2_r) begin
      rem_r <= diff[tet_pkg::BUCKET_W-1:0];
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

// ===== rtl/tet_cell.sv =====
// ----------------------------------------------------------------------------
// tet_cell: one slot of the task entry table
// Holds one entry, compares it against the lookup keys, takes its upper
// neighbor's entry when the row compacts.
// ----------------------------------------------------------------------------
module tet_cell (
  input  logic                         clk,
  input  logic                         rst_n,
  input  tet_pkg::tet_cell_ctrl_t      ctrl,
  input  tet_pkg::tet_entry_t          wdata,
  input  tet_pkg::tet_entry_t          above,
  input  logic [30:0]                  key_task,
  input  logic signed [16:0]           key_sock,
  input  logic [tet_pkg::BUCKET_W-1:0] key_bucket,
  output tet_pkg::tet_entry_t          entry,
  output tet_pkg::tet_cell_flags_t     flags
);

  logic                valid_r;
  tet_pkg::tet_entry_t ent_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctrl.kill) begin
      valid_r <= 1'b0;
    end else if (ctrl.load) begin
      valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      ent_r <= wdata;
    end else if (ctrl.shift) begin
      ent_r <= above;
    end else if (ctrl.dec) begin
      if (ent_r.refs != 2'd0) begin
        ent_r.refs <= ent_r.refs - 2'd1;
      end
    end else if (ctrl.lose && valid_r && ent_r.socket == key_sock) begin
      ent_r.socket <= tet_pkg::SOCK_LOST;
    end
  end

  assign entry            = ent_r;
  assign flags.valid      = valid_r;
  assign flags.task_hit   = valid_r && (ent_r.task_id == key_task);
  assign flags.sock_hit   = valid_r && (ent_r.socket == key_sock);
  assign flags.bucket_hit = valid_r && (ent_r.bucket == key_bucket);

endmodule

// ===== rtl/task_entry_table.sv =====
// ----------------------------------------------------------------------------
// task_entry_table: reference-counted table of task entries
// A row of slot cells kept packed oldest first, with a pipelined bucket unit.
// ----------------------------------------------------------------------------
// Usage:
//   Drive in_* and raise start; the command transaction is taken at an edge
//   where start is high and busy is low. busy stays high while a command is
//   worked on. Each result appears for one cycle with out_valid high; the
//   receiver cannot stall, so results are never held. out_last marks the
//   final result of a command.
// Command sequences:
//   find, find-ignoring-connection and not-found remove: latch the hit
//   slots, pick the newest, answer. remove: decrement, then answer and,
//   at a zero count, compact the row in one pass where every cell from
//   the freed slot up takes its neighbor's entry. lost connection: all
//   cells compare and update at once. register: the bucket unit (byte
//   fold, reciprocal multiply, remainder), then the cell load, then the
//   answer; a full table answers at the accept edge. list: per bucket,
//   load the matches and emit them one by one; a final count result ends it.
// Reset:
//   rst_n clears every slot valid bit and the fill count; slot payloads
//   stay as they are and are never read while invalid.
// ----------------------------------------------------------------------------
module task_entry_table #(
  parameter int TABLE_DEPTH = tet_pkg::DEFAULT_DEPTH,
  parameter int BUCKETS     = tet_pkg::DEFAULT_BUCKETS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_mode,
  input  logic [30:0]        in_task_id,
  input  logic signed [16:0] in_socket,
  input  logic [15:0]        in_task_port,
  input  logic               in_with_task_info,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic [30:0]        out_found_task,
  output logic signed [16:0] out_found_socket,
  output logic [15:0]        out_found_port,
  output logic [1:0]         out_found_refs,
  output logic               out_found_eof,
  output logic               out_entry_present,
  output logic [5:0]         out_match_count,
  output logic               out_last
);

  localparam int N  = TABLE_DEPTH;
  localparam int UW = $clog2(TABLE_DEPTH + 1);
  localparam int BW = tet_pkg::BUCKET_W;
  localparam logic [BW-1:0] LAST_BKT = BW'(BUCKETS - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_MOD, S_EMIT, S_LOOK, S_PICK, S_REME, S_LLOAD, S_LEMIT
  } state_t;

  state_t             state_r, state_nxt;
  logic [2:0]         mode_r;
  logic [30:0]        task_r;
  logic signed [16:0] sock_r;
  logic [15:0]        port_r;
  logic               info_r;
  logic [UW-1:0]      used_r, used_nxt;
  logic [N-1:0]       vec_r, vec_nxt;
  logic [BW-1:0]      bkt_r, bkt_nxt;
  logic [5:0]         cnt_r, cnt_nxt;

  tet_pkg::tet_entry_t      ent   [N];
  tet_pkg::tet_entry_t      above [N];
  tet_pkg::tet_cell_flags_t flg   [N];
  tet_pkg::tet_cell_ctrl_t  ctl   [N];
  tet_pkg::tet_entry_t      wdata;

  logic          mod_start, mod_done;
  logic [BW-1:0] mod_rem;
  logic          accept;

  logic [N-1:0]  pick, ge_mask, hit_vec, list_vec, valid_vec;
  logic [N-1:0]  emit_sel;
  logic          emit_en, emit_last;
  logic [1:0]    emit_status;
  logic [5:0]    emit_cnt;
  tet_pkg::tet_entry_t pick_ent, emit_ent;

  // isolate the highest set bit: the newest entry among the candidates
  function automatic logic [N-1:0] top_bit(input logic [N-1:0] v);
    logic [N-1:0] r, l, o;
    for (int j = 0; j < N; j++) r[j] = v[N-1-j];
    l = r & (~r + 1'b1);
    for (int j = 0; j < N; j++) o[j] = l[N-1-j];
    return o;
  endfunction

  function automatic tet_pkg::tet_entry_t sel_entry(input logic [N-1:0] s,
                                                   input tet_pkg::tet_entry_t e [N]);
    tet_pkg::tet_entry_t acc;
    acc = '0;
    for (int j = 0; j < N; j++) begin
      if (s[j]) acc = acc | e[j];
    end
    return acc;
  endfunction

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  // the bucket unit takes the task id straight from the input at accept
  tet_mod #(.BUCKETS(BUCKETS)) u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mod_start),
    .din   (in_task_id),
    .done  (mod_done),
    .rem   (mod_rem)
  );

  always_comb begin
    wdata.task_id = task_r;
    wdata.socket  = sock_r;
    wdata.port    = port_r;
    wdata.refs    = info_r ? 2'd2 : 2'd1;
    wdata.eof     = !info_r;
    wdata.bucket  = mod_rem;
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    if (i == N - 1) begin : g_top
      assign above[i] = ent[i];
    end else begin : g_mid
      assign above[i] = ent[i+1];
    end

    assign hit_vec[i]   = flg[i].task_hit;
    assign list_vec[i]  = flg[i].sock_hit && flg[i].bucket_hit;
    assign valid_vec[i] = flg[i].valid;

    always_comb begin
      ctl[i].load  = (state_r == S_MOD) && mod_done && (used_r == UW'(i));
      ctl[i].dec   = (state_r == S_PICK) && (mode_r == tet_pkg::MODE_REM) && pick[i];
      ctl[i].shift = (state_r == S_REME) && (pick_ent.refs == 2'd0) && ge_mask[i];
      ctl[i].kill  = (state_r == S_REME) && (pick_ent.refs == 2'd0) &&
                     (used_r == UW'(i + 1));
      ctl[i].lose  = (state_r == S_IDLE) && accept && (in_mode == tet_pkg::MODE_LOST);
    end

    tet_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctl[i]),
      .wdata      (wdata),
      .above      (above[i]),
      .key_task   (task_r),
      .key_sock   ((state_r == S_IDLE) ? in_socket : sock_r),
      .key_bucket (bkt_r),
      .entry      (ent[i]),
      .flags      (flg[i])
    );
  end

  // in S_PICK and S_LEMIT the candidates sit in vec_r; in S_REME vec_r
  // already holds the one-hot slot being removed
  assign pick     = (state_r == S_REME) ? vec_r : top_bit(vec_r);
  assign ge_mask  = ~(pick - 1'b1);
  assign pick_ent = sel_entry(pick, ent);
  assign emit_ent = sel_entry(emit_sel, ent);

  always_comb begin
    state_nxt   = state_r;
    used_nxt    = used_r;
    vec_nxt     = vec_r;
    bkt_nxt     = bkt_r;
    cnt_nxt     = cnt_r;
    mod_start   = 1'b0;
    emit_en     = 1'b0;
    emit_status = tet_pkg::ST_OK;
    emit_sel    = '0;
    emit_cnt    = '0;
    emit_last   = 1'b1;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_mode) inside
            tet_pkg::MODE_REG: begin
              if (used_r == UW'(TABLE_DEPTH)) begin
                emit_en     = 1'b1;
                emit_status = tet_pkg::ST_FULL;
              end else begin
                state_nxt = S_MOD;
              end
            end
            tet_pkg::MODE_REM, tet_pkg::MODE_FIND, tet_pkg::MODE_FINDI: begin
              state_nxt = S_LOOK;
            end
            tet_pkg::MODE_LIST: begin
              bkt_nxt   = '0;
              cnt_nxt   = '0;
              state_nxt = S_LLOAD;
            end
            default: begin
              // lost connection updates the cells at this edge; unknown
              // modes only answer
              emit_en = 1'b1;
            end
          endcase
        end
      end
      S_MOD: begin
        if (mod_done) begin
          vec_nxt   = N'(1) << used_r;
          used_nxt  = used_r + 1'b1;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        emit_en   = 1'b1;
        emit_sel  = vec_r;
        state_nxt = S_IDLE;
      end
      S_LOOK: begin
        vec_nxt   = hit_vec;
        state_nxt = S_PICK;
      end
      S_PICK: begin
        if (vec_r == '0) begin
          emit_en     = 1'b1;
          emit_status = tet_pkg::ST_NOTFOUND;
          state_nxt   = S_IDLE;
        end else if (mode_r == tet_pkg::MODE_REM) begin
          vec_nxt   = pick;
          state_nxt = S_REME;
        end else if (mode_r == tet_pkg::MODE_FIND && pick_ent.socket == tet_pkg::SOCK_LOST) begin
          emit_en     = 1'b1;
          emit_status = tet_pkg::ST_CONNLOST;
          state_nxt   = S_IDLE;
        end else begin
          emit_en   = 1'b1;
          emit_sel  = pick;
          state_nxt = S_IDLE;
        end
      end
      S_REME: begin
        // report the count after the decrement, then compact if it is zero
        emit_en   = 1'b1;
        emit_sel  = vec_r;
        if (pick_ent.refs == 2'd0) begin
          used_nxt = used_r - 1'b1;
        end
        state_nxt = S_IDLE;
      end
      S_LLOAD: begin
        vec_nxt   = list_vec;
        state_nxt = S_LEMIT;
      end
      S_LEMIT: begin
        if (vec_r != '0) begin
          cnt_nxt   = cnt_r + 6'd1;
          emit_en   = 1'b1;
          emit_sel  = pick;
          emit_cnt  = cnt_r + 6'd1;
          emit_last = 1'b0;
          vec_nxt   = vec_r & ~pick;
        end else if (bkt_r == LAST_BKT) begin
          emit_en   = 1'b1;
          emit_cnt  = cnt_r;
          state_nxt = S_IDLE;
        end else begin
          bkt_nxt   = bkt_r + 1'b1;
          state_nxt = S_LLOAD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (state_r == S_IDLE && state_nxt == S_MOD) begin
      mod_start = 1'b1;
    end
  end

  // command latch: the bucket unit starts at the same accept edge
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r <= in_mode;
      task_r <= in_task_id;
      sock_r <= in_socket;
      port_r <= in_task_port;
      info_r <= in_with_task_info;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      used_r    <= '0;
      out_valid <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      used_r    <= used_nxt;
      out_valid <= emit_en;
    end
    vec_r <= vec_nxt;
    bkt_r <= bkt_nxt;
    cnt_r <= cnt_nxt;
    if (emit_en) begin
      out_status        <= emit_status;
      out_found_task    <= emit_ent.task_id;
      out_found_socket  <= emit_ent.socket;
      out_found_port    <= emit_ent.port;
      out_found_refs    <= emit_ent.refs;
      out_found_eof     <= emit_ent.eof;
      out_entry_present <= (emit_sel != '0);
      out_match_count   <= emit_cnt;
      out_last          <= emit_last;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= UW'(TABLE_DEPTH))
    else $error("fill count beyond table depth");

  a_packed_row: assert property (@(posedge clk) disable iff (!rst_n)
    valid_vec == N'(((N+1)'(1) << used_r) - 1'b1))
    else $error("valid slots are not a packed prefix");

  a_remove_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_REME |-> $onehot(vec_r))
    else $error("remove without a single selected slot");

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_entry_present |-> out_found_task == '0 && out_found_refs == '0)
    else $error("result without entry carries entry data");

endmodule
